// File: rtl/scl_pkg.sv
package scl_pkg;

    localparam int ROWS_DEF = 16;
    localparam int COLS_DEF = 32;

    localparam int COL_W = 16;
    localparam int OUT_W = 2 * COL_W;
    localparam int IDX_W = 5;

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic e0;
        logic e1;
        logic e2;
        logic e3;
    } scl_corners_t;

    typedef struct packed {
        logic [OUT_W-1:0] even_column;
        logic [OUT_W-1:0] odd_column;
        logic [IDX_W-1:0] source_index;
        logic             last_of_run;
        logic             frame_done;
    } scl_result_t;

endpackage

// File: rtl/scl_lane.sv
module scl_lane
    import scl_pkg::*;
(
    input  logic         pix,
    input  logic         up,
    input  logic         dn,
    input  logic         lf,
    input  logic         rt,
    output scl_corners_t corners
);

    logic edge_pix;

    // corners only differ from the centre across a diagonal edge
    assign edge_pix = (up != dn) && (lf != rt);

    always_comb begin
        corners.e0 = pix;
        corners.e1 = pix;
        corners.e2 = pix;
        corners.e3 = pix;
        if (edge_pix) begin
            corners.e0 = (lf == up) ? lf : pix;
            corners.e1 = (up == rt) ? rt : pix;
            corners.e2 = (lf == dn) ? lf : pix;
            corners.e3 = (dn == rt) ? rt : pix;
        end
    end

endmodule

// File: rtl/scl_expand.sv
module scl_expand
    import scl_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
) (
    input  logic [COL_W-1:0] left_col,
    input  logic [COL_W-1:0] centre_col,
    input  logic [COL_W-1:0] right_col,
    input  logic             has_left,
    input  logic             has_right,
    output logic [OUT_W-1:0] even_col,
    output logic [OUT_W-1:0] odd_col
);

    localparam int EFF_ROWS = (ROWS > COL_W) ? COL_W : ROWS;

    for (genvar r = 0; r < COL_W; r++) begin : g_row
        if (r < EFF_ROWS) begin : g_lane
            logic         p;
            logic         up;
            logic         dn;
            logic         lf;
            logic         rt;
            scl_corners_t c;

            assign p = centre_col[r];
            if (r > 0) begin : g_up
                assign up = centre_col[r-1];
            end else begin : g_up_edge
                assign up = p;
            end
            if (r < EFF_ROWS - 1) begin : g_dn
                assign dn = centre_col[r+1];
            end else begin : g_dn_edge
                assign dn = p;
            end
            assign lf = has_left  ? left_col[r]  : p;
            assign rt = has_right ? right_col[r] : p;

            scl_lane u_lane (
                .pix     (p),
                .up      (up),
                .dn      (dn),
                .lf      (lf),
                .rt      (rt),
                .corners (c)
            );

            // merge lane corners into the two output columns
            assign even_col[2*r]   = c.e0;
            assign even_col[2*r+1] = c.e2;
            assign odd_col[2*r]    = c.e1;
            assign odd_col[2*r+1]  = c.e3;
        end else begin : g_unused
            assign even_col[2*r+1:2*r] = 2'b00;
            assign odd_col[2*r+1:2*r]  = 2'b00;
        end
    end

endmodule

// File: rtl/scale2x_column_expander.sv
// scale2x column expander: 2x pixel-art upscaler for a 1-bit frame
//
// input beats on s_ (valid/ready) carry one source column each, left to
// right, bit r = row r. result beats on m_ (valid/ready) carry the two
// output columns that expand one source column, its index and flags.
// the first column of a frame gives no result; every later column gives
// the pair for the column before it; the frame's last column gives two
// results, the second with m_frame_done set, and the column count restarts.
// m_last_of_run marks the final result caused by an input beat.
// a result is written into the result queue when its input beat is taken.
// throughput: one column per cycle while s_ready is high, set by the row
// lanes that expand a column combinationally and a 4-entry result queue;
// s_ready drops while the queue has fewer than two free entries.
// when the receiver stalls, results wait in the queue and s_ready falls
// once it is nearly full. reset (aresetn low, synchronous) empties the
// queue and clears the held columns and the column count.
module scale2x_column_expander
    import scl_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [COL_W-1:0] s_column_bits,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [OUT_W-1:0] m_even_column,
    output logic [OUT_W-1:0] m_odd_column,
    output logic [IDX_W-1:0] m_source_index,
    output logic             m_last_of_run,
    output logic             m_frame_done
);

    localparam int CNT_W = $clog2(COLS);
    localparam int IW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic [COL_W-1:0] left_reg,   left_next;
    logic [COL_W-1:0] centre_reg, centre_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    scl_result_t      fifo_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] fcnt_reg,   fcnt_next;

    logic             in_fire;
    logic             out_fire;
    logic             first_col;
    logic             final_col;
    logic             push_a;
    logic             push_b;
    logic [IW-1:0]    idx_wide;
    logic [IW-1:0]    last_idx_wide;
    logic [OUT_W-1:0] even_a, odd_a, even_b, odd_b;
    scl_result_t      res_a, res_b;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign s_ready  = (fcnt_reg <= FCNT_W'(FIFO_DEPTH - 2));

    assign first_col     = (cnt_reg == '0);
    assign final_col     = (cnt_reg >= CNT_W'(COLS - 1));
    assign idx_wide      = IW'(cnt_reg) - IW'(1);
    assign last_idx_wide = IW'(COLS - 1);

    assign push_a = in_fire && !first_col;
    assign push_b = push_a && final_col;

    // pair for the centre column, right neighbour is the new column
    scl_expand #(.ROWS(ROWS)) u_expand_a (
        .left_col   (left_reg),
        .centre_col (centre_reg),
        .right_col  (s_column_bits),
        .has_left   (cnt_reg > CNT_W'(1)),
        .has_right  (1'b1),
        .even_col   (even_a),
        .odd_col    (odd_a)
    );

    // pair for the frame's last column, no right neighbour
    scl_expand #(.ROWS(ROWS)) u_expand_b (
        .left_col   (centre_reg),
        .centre_col (s_column_bits),
        .right_col  ('0),
        .has_left   (1'b1),
        .has_right  (1'b0),
        .even_col   (even_b),
        .odd_col    (odd_b)
    );

    always_comb begin
        res_a.even_column  = even_a;
        res_a.odd_column   = odd_a;
        res_a.source_index = idx_wide[IDX_W-1:0];
        res_a.last_of_run  = !final_col;
        res_a.frame_done   = 1'b0;
        res_b.even_column  = even_b;
        res_b.odd_column   = odd_b;
        res_b.source_index = last_idx_wide[IDX_W-1:0];
        res_b.last_of_run  = 1'b1;
        res_b.frame_done   = 1'b1;
    end

    always_comb begin
        left_next   = left_reg;
        centre_next = centre_reg;
        cnt_next    = cnt_reg;
        if (in_fire) begin
            if (first_col) begin
                left_next   = '0;
                centre_next = s_column_bits;
                cnt_next    = CNT_W'(1);
            end else if (final_col) begin
                left_next   = '0;
                centre_next = '0;
                cnt_next    = '0;
            end else begin
                left_next   = centre_reg;
                centre_next = s_column_bits;
                cnt_next    = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FPTR_W'(push_a) + FPTR_W'(push_b);
        rd_ptr_next = rd_ptr_reg + FPTR_W'(out_fire);
        fcnt_next   = fcnt_reg + FCNT_W'(push_a) + FCNT_W'(push_b) - FCNT_W'(out_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            centre_reg <= '0;
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end else begin
            left_reg   <= left_next;
            centre_reg <= centre_next;
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fcnt_reg   <= fcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_a) begin
            fifo_reg[wr_ptr_reg] <= res_a;
        end
        if (push_b) begin
            fifo_reg[wr_ptr_reg + FPTR_W'(1)] <= res_b;
        end
    end

    assign m_valid        = (fcnt_reg != '0);
    assign m_even_column  = fifo_reg[rd_ptr_reg].even_column;
    assign m_odd_column   = fifo_reg[rd_ptr_reg].odd_column;
    assign m_source_index = fifo_reg[rd_ptr_reg].source_index;
    assign m_last_of_run  = fifo_reg[rd_ptr_reg].last_of_run;
    assign m_frame_done   = fifo_reg[rd_ptr_reg].frame_done;

endmodule

// File: rtl/scl_checker.sv
module scl_checker
    import scl_pkg::*;
#(
    parameter int COLS = COLS_DEF
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [OUT_W-1:0] m_even_column,
    input logic [OUT_W-1:0] m_odd_column,
    input logic [IDX_W-1:0] m_source_index,
    input logic             m_last_of_run,
    input logic             m_frame_done
);

    localparam int LAST_IDX_W = (IDX_W > 9) ? IDX_W : 9;
    localparam logic [LAST_IDX_W-1:0] LAST_IDX = LAST_IDX_W'(COLS - 1);

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_even_column)
            && $stable(m_odd_column) && $stable(m_source_index))
        else $error("result beat changed while stalled");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_last_of_run)
        else $error("frame_done without last_of_run");

    a_done_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_source_index == LAST_IDX[IDX_W-1:0])
        else $error("frame_done on wrong column index");

    // the second result of the final column is already queued
    a_run_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid && m_frame_done)
        else $error("missing second result of the final column");

endmodule

bind scale2x_column_expander scl_checker #(.COLS(COLS)) u_scl_checker (.*);

// File: tb/scale2x_column_expander_tb.sv
`timescale 1ns / 1ps

module scale2x_column_expander_tb;
    import scl_pkg::*;

    localparam int ROWS = ROWS_DEF;
    localparam int COLS = COLS_DEF;
    localparam int LIVE_ROWS = (ROWS > COL_W) ? COL_W : ROWS;
    localparam int RANDOM_COLUMNS = 1650;

    // tracks the held columns and predicts every expanded column pair
    class expansion_tracker;
        logic [COL_W-1:0] left_col;
        logic [COL_W-1:0] centre_col;
        int               columns_seen;
        scl_result_t      pending_pairs[$];
        int               mismatches;

        function new();
            left_col     = '0;
            centre_col   = '0;
            columns_seen = 0;
            mismatches   = 0;
        endfunction

        function scl_result_t expand_pixels(logic [COL_W-1:0] l, logic [COL_W-1:0] c,
                                            logic [COL_W-1:0] r, bit has_l, bit has_r,
                                            int idx, bit last, bit done);
            scl_result_t  res;
            scl_corners_t k;
            logic p, up, dn, lf, rt;
            res = '0;
            for (int y = 0; y < LIVE_ROWS; y++) begin
                p  = c[y];
                up = (y > 0) ? c[y-1] : p;
                dn = (y < LIVE_ROWS - 1) ? c[y+1] : p;
                lf = has_l ? l[y] : p;
                rt = has_r ? r[y] : p;
                k  = '{p, p, p, p};
                if (up != dn && lf != rt) begin
                    k.e0 = (lf == up) ? lf : p;
                    k.e1 = (up == rt) ? rt : p;
                    k.e2 = (lf == dn) ? lf : p;
                    k.e3 = (dn == rt) ? rt : p;
                end
                res.even_column[2*y]   = k.e0;
                res.even_column[2*y+1] = k.e2;
                res.odd_column[2*y]    = k.e1;
                res.odd_column[2*y+1]  = k.e3;
            end
            res.source_index = idx[IDX_W-1:0];
            res.last_of_run  = last;
            res.frame_done   = done;
            return res;
        endfunction

        function void take_column(logic [COL_W-1:0] raw);
            logic [COL_W-1:0] x;
            int               idx;
            bit               final_col;
            x = raw & ((COL_W'(1) << LIVE_ROWS) - COL_W'(1));
            if (LIVE_ROWS == COL_W)
                x = raw;
            if (columns_seen == 0) begin
                // first column of a frame is only stored
                left_col     = '0;
                centre_col   = x;
                columns_seen = 1;
                return;
            end
            idx       = columns_seen - 1;
            final_col = (columns_seen >= COLS - 1);
            pending_pairs.push_back(expand_pixels(left_col, centre_col, x, idx > 0, 1'b1,
                                                  idx, !final_col, 1'b0));
            left_col     = centre_col;
            centre_col   = x;
            columns_seen = columns_seen + 1;
            if (final_col) begin
                // last column has no right neighbor and closes the frame
                pending_pairs.push_back(expand_pixels(left_col, centre_col, '0, 1'b1, 1'b0,
                                                      COLS - 1, 1'b1, 1'b1));
                left_col     = '0;
                centre_col   = '0;
                columns_seen = 0;
            end
        endfunction

        function void check_pair(scl_result_t got);
            scl_result_t want;
            if (pending_pairs.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result beat: even %h odd %h idx %0d last %b done %b",
                             got.even_column, got.odd_column, got.source_index,
                             got.last_of_run, got.frame_done);
                mismatches++;
                return;
            end
            want = pending_pairs.pop_front();
            if (got.even_column !== want.even_column || got.odd_column !== want.odd_column
                    || got.source_index !== want.source_index
                    || got.last_of_run !== want.last_of_run
                    || got.frame_done !== want.frame_done) begin
                if (mismatches < 10) begin
                    $display("mismatch at t=%0t column %0d:", $time, want.source_index);
                    $display("  even_column  exp %h got %h", want.even_column, got.even_column);
                    $display("  odd_column   exp %h got %h", want.odd_column, got.odd_column);
                    $display("  source_index exp %0d got %0d", want.source_index,
                             got.source_index);
                    $display("  last_of_run  exp %b got %b", want.last_of_run, got.last_of_run);
                    $display("  frame_done   exp %b got %b", want.frame_done, got.frame_done);
                end
                mismatches++;
            end
        endfunction

        function int waiting();
            return pending_pairs.size();
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [COL_W-1:0] s_column_bits;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [OUT_W-1:0] m_even_column;
    logic [OUT_W-1:0] m_odd_column;
    logic [IDX_W-1:0] m_source_index;
    logic             m_last_of_run;
    logic             m_frame_done;

    expansion_tracker tracker;
    logic [COL_W-1:0] prev_column;
    int               stall_mode = 0;
    int               stall_left = 0;
    int               stall_phase = 0;
    logic [7:0]       stall_pattern = 8'h5a;

    scale2x_column_expander #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_column_bits (s_column_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_even_column (m_even_column),
        .m_odd_column  (m_odd_column),
        .m_source_index(m_source_index),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // beats on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.take_column(s_column_bits);
            if (m_valid && m_ready)
                tracker.check_pair('{m_even_column, m_odd_column, m_source_index,
                                     m_last_of_run, m_frame_done});
        end
    end

    // receiver stalls on a pattern that changes mode now and then
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode    <= $urandom_range(0, 3);
            stall_left    <= $urandom_range(32, 200);
            stall_pattern <= $urandom_range(1, 255);
            stall_phase   <= 0;
        end else begin
            stall_left  <= stall_left - 1;
            stall_phase <= (stall_phase + 1) % 24;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= stall_pattern[stall_phase[2:0]];
            2: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= (stall_phase >= 18);
        endcase
    end

    task automatic send_column(input logic [COL_W-1:0] bits);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_column_bits <= bits;
        do
            @(posedge aclk);
        while (!s_ready);
        prev_column = bits;
    endtask

    task automatic hold_input(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        hold_input(1);
        while (tracker.waiting() != 0)
            @(posedge aclk);
    endtask

    // mostly edges and small changes from the previous column, so the
    // corner rules fire often
    function automatic logic [COL_W-1:0] next_column();
        logic [COL_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = COL_W'($urandom_range(0, 16'hffff));
            1: v = (COL_W'(1) << $urandom_range(0, COL_W - 1))
                   | (COL_W'(1) << $urandom_range(0, COL_W - 1));
            2: v = ~((COL_W'(1) << $urandom_range(0, COL_W - 1))
                   | (COL_W'(1) << $urandom_range(0, COL_W - 1)));
            3: v = $urandom_range(0, 1) ? (prev_column << 1) : (prev_column >> 1);
            4: v = prev_column ^ (COL_W'(1) << $urandom_range(0, COL_W - 1));
            default: v = prev_column;
        endcase
        return v;
    endfunction

    initial begin
        logic [COL_W-1:0] opening[$];
        int               sent;
        int               burst;

        tracker       = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_column_bits = '0;
        prev_column   = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        opening = '{16'h0000, 16'hffff, 16'h5555, 16'haaaa, 16'h0001, 16'h8000, 16'h0000,
                    16'hffff, 16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0, 16'h3333, 16'hcccc,
                    16'h1248, 16'h8421, 16'h0180, 16'h7ffe, 16'h8001, 16'h6996, 16'h9669,
                    16'h0000};
        foreach (opening[i])
            send_column(opening[i]);

        sent = 0;
        while (sent < RANDOM_COLUMNS) begin
            burst = $urandom_range(1, 64);
            for (int b = 0; b < burst && sent < RANDOM_COLUMNS; b++) begin
                send_column(next_column());
                sent++;
                if (sent == RANDOM_COLUMNS / 2)
                    wait_drained();
            end
            if ($urandom_range(0, 2) != 0)
                hold_input($urandom_range(1, 8));
        end

        hold_input(1);
        while (tracker.waiting() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.waiting() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
